FILE: design/joystick_to_direction_keys_assert.svh
// assertion macros for the joystick to direction keys block
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef JOYSTICK_TO_DIRECTION_KEYS_ASSERT_SVH
`define JOYSTICK_TO_DIRECTION_KEYS_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define JTDK_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define JTDK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define JTDK_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define JTDK_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: design/jtdk_pkg.sv
// shared types and constants of the joystick to direction keys block
// no dependencies
package jtdk_pkg;

   // speed grades
   localparam logic [1:0] SPD_NONE = 2'd0;
   localparam logic [1:0] SPD_SLOW = 2'd1;
   localparam logic [1:0] SPD_FAST = 2'd2;

   // csr register indexes
   localparam logic CSR_START_THRESHOLD = 1'b0;
   localparam logic CSR_SLOW_BAND       = 1'b1;

   localparam logic [7:0] START_THRESHOLD_RESET = 8'd2;
   localparam logic [7:0] SLOW_BAND_RESET       = 8'd2;

   localparam int N_AXES  = 2;
   localparam int N_WORDS = 4;

   typedef struct packed {
      logic slow;
      logic neg;
      logic valid;
   } held_type;

   typedef struct packed {
      held_type   held;
      logic [1:0] speed;
      logic       dir;
   } axis_state_type;

   typedef struct packed {
      logic press;
      logic neg;
      logic slow;
   } key_event_type;

   // ev[0] goes out first
   typedef struct packed {
      logic [1:0]               count;
      key_event_type [1:0]      ev;
   } lane_out_type;

   typedef struct packed {
      logic axis_sel;
      logic press;
      logic negative_dir;
      logic slow_key;
   } word_type;

endpackage

FILE: design/jtdk_ifs.sv
// valid/ready channel interfaces for reports and key event words
// no dependencies
interface jtdk_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] x_motion;
   logic signed [7:0] y_motion;
   logic              game_mode;

   modport source (output valid, x_motion, y_motion, game_mode, input ready);
   modport sink   (input valid, x_motion, y_motion, game_mode, output ready);
endinterface

interface jtdk_rsp_if;
   logic valid;
   logic ready;
   logic axis_sel;
   logic press;
   logic negative_dir;
   logic slow_key;
   logic last;

   modport source (output valid, axis_sel, press, negative_dir, slow_key, last, input ready);
   modport sink   (input valid, axis_sel, press, negative_dir, slow_key, last, output ready);
endinterface

FILE: design/jtdk_lane.sv
// one axis lane: grades the motion and finds the release/press events
// depends on jtdk_pkg
module jtdk_lane (
   input  logic signed [7:0]       motion,
   input  logic                    game_mode,
   input  logic [7:0]              start_threshold,
   input  logic [7:0]              slow_band,
   input  jtdk_pkg::axis_state_type state_cur,
   output jtdk_pkg::axis_state_type state_nxt,
   output jtdk_pkg::lane_out_type   lane_out
);
   import jtdk_pkg::*;

   logic          neg;
   logic [7:0]    motion_u;
   logic [7:0]    mag;
   logic [8:0]    upper;
   logic [1:0]    spd;
   logic          changed;
   held_type      new_key;
   key_event_type rel_ev;
   key_event_type press_ev;

   always_comb begin
      neg      = motion[7];
      motion_u = unsigned'(motion);
      mag      = neg ? (8'd0 - motion_u) : motion_u;
      upper    = {1'b0, start_threshold} + {1'b0, slow_band};
      if (mag < start_threshold) begin
         spd = SPD_NONE;
      end else if ({1'b0, mag} < upper) begin
         spd = SPD_SLOW;
      end else begin
         spd = SPD_FAST;
      end
      changed  = (spd != state_cur.speed) || (neg != state_cur.dir);
      new_key  = '{slow: (spd == SPD_SLOW), neg: neg, valid: 1'b1};
      rel_ev   = '{press: 1'b0, neg: state_cur.held.neg, slow: state_cur.held.slow};
      press_ev = '{press: 1'b1, neg: new_key.neg, slow: new_key.slow};

      state_nxt = state_cur;
      lane_out  = '0;

      if (!game_mode) begin
         // release whatever is held, forget the speed, keep the direction
         if (state_cur.held.valid) begin
            lane_out.count = 2'd1;
            lane_out.ev[0] = rel_ev;
         end
         state_nxt.held  = '0;
         state_nxt.speed = SPD_NONE;
      end else begin
         state_nxt.speed = spd;
         state_nxt.dir   = neg;
         if (changed) begin
            if (spd == SPD_NONE) begin
               if (state_cur.held.valid) begin
                  lane_out.count = 2'd1;
                  lane_out.ev[0] = rel_ev;
               end
               state_nxt.held = '0;
            end else begin
               // release the old key only once and only if it differs
               if (state_cur.held.valid && (state_cur.held != new_key)) begin
                  lane_out.count = 2'd2;
                  lane_out.ev[0] = rel_ev;
                  lane_out.ev[1] = press_ev;
               end else begin
                  lane_out.count = 2'd1;
                  lane_out.ev[0] = press_ev;
               end
               state_nxt.held = new_key;
            end
         end
      end
   end

endmodule

FILE: design/jtdk_merge.sv
// packs the events of both lanes into one ordered list, horizontal first
// depends on jtdk_pkg
module jtdk_merge (
   input  jtdk_pkg::lane_out_type          x_out,
   input  jtdk_pkg::lane_out_type          y_out,
   output jtdk_pkg::word_type [3:0]        words,
   output logic [2:0]                      count
);
   import jtdk_pkg::*;

   logic [1:0] slot;

   always_comb begin
      words = '0;
      slot  = '0;
      for (int k = 0; k < 2; k++) begin
         if (2'(k) < x_out.count) begin
            words[k] = '{axis_sel: 1'b0, press: x_out.ev[k].press,
                         negative_dir: x_out.ev[k].neg, slow_key: x_out.ev[k].slow};
         end
      end
      for (int k = 0; k < 2; k++) begin
         slot = x_out.count + 2'(k);
         if (2'(k) < y_out.count) begin
            words[slot] = '{axis_sel: 1'b1, press: y_out.ev[k].press,
                            negative_dir: y_out.ev[k].neg, slow_key: y_out.ev[k].slow};
         end
      end
      count = {1'b0, x_out.count} + {1'b0, y_out.count};
   end

endmodule

FILE: design/joystick_to_direction_keys.sv
// top level of the joystick to direction keys block
// depends on jtdk_pkg, jtdk_ifs, jtdk_lane, jtdk_merge and the assert macro header
`include "joystick_to_direction_keys_assert.svh"

// Turns pointing-device reports into direction-key press and release words.
// Each report gives 0 to 4 words, horizontal axis first, the final one marked
// with last. Words leave one per cycle while the receiver is ready, from a
// four-entry output buffer; the next report is taken in the same cycle the
// last word of the previous one is taken, and a report that gives no word is
// taken every cycle. The output buffer drain is what sets the rate. The two
// thresholds are csr registers 0 (start threshold) and 1 (slow band), both
// resetting to 2; write them only while idle.
module joystick_to_direction_keys (
   input  logic        clock,
   input  logic        reset,
   jtdk_req_if.sink    req_ch,
   jtdk_rsp_if.source  rsp_ch,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   import jtdk_pkg::*;

   // csr registers
   logic [7:0] start_threshold_ff, start_threshold_in;
   logic [7:0] slow_band_ff, slow_band_in;

   // per axis held key, speed and direction
   axis_state_type [N_AXES-1:0] axis_ff, axis_in;
   axis_state_type [N_AXES-1:0] axis_nxt;
   lane_out_type   [N_AXES-1:0] lane_out;

   // output buffer: words of one report, read pointer, words left
   word_type [N_WORDS-1:0] words_ff, words_in;
   logic [1:0]             rd_ff, rd_in;
   logic [2:0]             rem_ff, rem_in;

   word_type [N_WORDS-1:0] merged_words;
   logic [2:0]             merged_count;
   logic                   req_take;
   logic                   rsp_take;
   word_type               head;

   // one lane per axis, both working on the same report
   jtdk_lane u_lane_x (
      .motion          (req_ch.x_motion),
      .game_mode       (req_ch.game_mode),
      .start_threshold (start_threshold_ff),
      .slow_band       (slow_band_ff),
      .state_cur       (axis_ff[0]),
      .state_nxt       (axis_nxt[0]),
      .lane_out        (lane_out[0])
   );

   jtdk_lane u_lane_y (
      .motion          (req_ch.y_motion),
      .game_mode       (req_ch.game_mode),
      .start_threshold (start_threshold_ff),
      .slow_band       (slow_band_ff),
      .state_cur       (axis_ff[1]),
      .state_nxt       (axis_nxt[1]),
      .lane_out        (lane_out[1])
   );

   jtdk_merge u_merge (
      .x_out (lane_out[0]),
      .y_out (lane_out[1]),
      .words (merged_words),
      .count (merged_count)
   );

   // output side
   assign head                = words_ff[rd_ff];
   assign rsp_ch.valid        = (rem_ff != 3'd0);
   assign rsp_ch.axis_sel     = head.axis_sel;
   assign rsp_ch.press        = head.press;
   assign rsp_ch.negative_dir = head.negative_dir;
   assign rsp_ch.slow_key     = head.slow_key;
   assign rsp_ch.last         = (rem_ff == 3'd1);
   assign rsp_take            = rsp_ch.valid && rsp_ch.ready;

   // take a report when the buffer is empty or its last word leaves now
   assign req_ch.ready = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_ch.ready);
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      start_threshold_in = start_threshold_ff;
      slow_band_in       = slow_band_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_THRESHOLD: start_threshold_in = csr_data;
            CSR_SLOW_BAND:       slow_band_in       = csr_data;
            default:             ;
         endcase
      end

      axis_in  = axis_ff;
      words_in = words_ff;
      rd_in    = rd_ff;
      rem_in   = rem_ff;
      if (req_take) begin
         // a fresh report replaces the drained buffer
         axis_in  = axis_nxt;
         words_in = merged_words;
         rd_in    = '0;
         rem_in   = merged_count;
      end else if (rsp_take) begin
         rd_in  = rd_ff + 2'd1;
         rem_in = rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_threshold_ff <= START_THRESHOLD_RESET;
         slow_band_ff       <= SLOW_BAND_RESET;
         axis_ff            <= '0;
         rd_ff              <= '0;
         rem_ff             <= '0;
      end else begin
         start_threshold_ff <= start_threshold_in;
         slow_band_ff       <= slow_band_in;
         axis_ff            <= axis_in;
         rd_ff              <= rd_in;
         rem_ff             <= rem_in;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

   // a report is only taken once the buffer is drained or draining
   `JTDK_ASSERT_IMPL(a_take_when_drained, clock, reset, req_take, (rem_ff == 3'd0) || (rem_ff == 3'd1 && rsp_take), "report taken over pending words")

   // the buffer holds exactly the words of the report just taken
   `JTDK_ASSERT_NEXT(a_fill_count, clock, reset, req_take, rem_ff == $past(merged_count), "word count mismatch after report")

   // a word not marked last is followed by another
   `JTDK_ASSERT_NEXT(a_more_words, clock, reset, rsp_take && !rsp_ch.last, rsp_ch.valid, "words of a report lost")

   // game mode off leaves nothing held and no stored speed
   `JTDK_ASSERT_NEXT(a_mode_off_clear, clock, reset, req_take && !req_ch.game_mode, !axis_ff[0].held.valid && !axis_ff[1].held.valid && axis_ff[0].speed == SPD_NONE && axis_ff[1].speed == SPD_NONE, "keys held after game mode off")

endmodule
